// ----- src/rtnh_pkg.sv -----
`timescale 1ns / 1ps
package rtnh_pkg;

  localparam int unsigned MaxFacesDefault = 65536;
  localparam int unsigned FaceW = 16;
  localparam int unsigned CoordW = 16;
  localparam int unsigned EdgeW = 17;
  localparam int unsigned VecW = 35;
  localparam int unsigned ProdW = 52;
  localparam int unsigned AccW = 56;
  localparam int unsigned DistW = 32;
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;
  localparam int unsigned StepW = 6;
  localparam int unsigned NumSteps = 33;
  localparam int unsigned DivSteps = 32;
  localparam int unsigned DivCntW = 6;

  // Register indexes.
  localparam logic [2:0] RegOriginX = 3'd0;
  localparam logic [2:0] RegOriginY = 3'd1;
  localparam logic [2:0] RegOriginZ = 3'd2;
  localparam logic [2:0] RegDirX    = 3'd3;
  localparam logic [2:0] RegDirY    = 3'd4;
  localparam logic [2:0] RegDirZ    = 3'd5;
  localparam logic [2:0] RegCull    = 3'd6;
  localparam logic [2:0] RegMinDist = 3'd7;

  typedef enum logic [1:0] {
    A_E1, A_E2, A_S, A_DIR
  } a_src_t;

  typedef enum logic [2:0] {
    B_DIR, B_S, B_E1, B_H, B_Q, B_N
  } b_src_t;

  typedef enum logic [2:0] {
    D_H, D_Q, D_N, D_DET, D_UN, D_VN, D_TN, D_ND
  } dest_t;

  typedef struct packed {
    a_src_t     a_src;
    logic [1:0] a_idx;
    b_src_t     b_src;
    logic [1:0] b_idx;
    logic       neg;
    logic       first;
    logic       last;
    dest_t      dest;
    logic [1:0] dst_idx;
  } mac_op_t;

  function automatic logic [1:0] idx_next(input logic [1:0] k);
    logic [1:0] r;
    case (k)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] idx_prev(input logic [1:0] k);
    logic [1:0] r;
    case (k)
      2'd0:    r = 2'd2;
      2'd1:    r = 2'd0;
      default: r = 2'd1;
    endcase
    return r;
  endfunction

  // Micro-op table of the multiply-accumulate sequence. Cross products P x Q
  // use A = Q and B = P; component k is P[k+1]*Q[k+2] - P[k+2]*Q[k+1].
  function automatic mac_op_t mac_op(input logic [StepW-1:0] step);
    mac_op_t    op;
    logic [2:0] j;
    logic [1:0] k;
    logic       second;
    op = '0;
    j = 3'd0;
    if (step < 6'd18) begin
      if (step < 6'd6) begin
        j = step[2:0];
        op.a_src = A_E2;
        op.b_src = B_DIR;
        op.dest = D_H;
      end else if (step < 6'd12) begin
        j = 3'(step - 6'd6);
        op.a_src = A_E1;
        op.b_src = B_S;
        op.dest = D_Q;
      end else begin
        j = 3'(step - 6'd12);
        op.a_src = A_E2;
        op.b_src = B_E1;
        op.dest = D_N;
      end
      k = j[2:1];
      second = j[0];
      op.a_idx = second ? idx_next(k) : idx_prev(k);
      op.b_idx = second ? idx_prev(k) : idx_next(k);
      op.neg = second;
      op.first = !second;
      op.last = second;
      op.dst_idx = k;
    end else begin
      if (step < 6'd21) begin
        j = 3'(step - 6'd18);
        op.a_src = A_E1;
        op.b_src = B_H;
        op.dest = D_DET;
      end else if (step < 6'd24) begin
        j = 3'(step - 6'd21);
        op.a_src = A_S;
        op.b_src = B_H;
        op.dest = D_UN;
      end else if (step < 6'd27) begin
        j = 3'(step - 6'd24);
        op.a_src = A_DIR;
        op.b_src = B_Q;
        op.dest = D_VN;
      end else if (step < 6'd30) begin
        j = 3'(step - 6'd27);
        op.a_src = A_E2;
        op.b_src = B_Q;
        op.dest = D_TN;
      end else begin
        j = 3'(step - 6'd30);
        op.a_src = A_DIR;
        op.b_src = B_N;
        op.dest = D_ND;
      end
      op.a_idx = j[1:0];
      op.b_idx = j[1:0];
      op.neg = 1'b0;
      op.first = (j == 3'd0);
      op.last = (j == 3'd2);
      op.dst_idx = 2'd0;
    end
    return op;
  endfunction

endpackage

// ----- src/ray_triangle_nearest_hit_top.sv -----
`timescale 1ns / 1ps
// Nearest ray/triangle hit over a stream of triangles.
// The user sets the ray (origin, direction), back-face culling and minimum
// distance via the APB-style register port while the block is idle; not enforced.
// Each request on the input channel carries one triangle (three Q8.8 vertices)
// and a flag that marks the last triangle of a mesh. The block runs an exact
// fixed-point Moller-Trumbore test and keeps the nearest accepted hit.
// One request runs the 33 products on the one shared 17 x 35 bit multiplier,
// the sign and inside checks, the bit-serial divider, then update, finish and
// a return to idle. A test that rejects the triangle skips the divider and the
// update; a saturated distance skips the divider.
// in_stall is high while a triangle is in work.
// On the last triangle one result request is issued on the output channel
// (hit, Q16.16 distance, unnormalized normal, face position), and the hit
// tracking and face counter clear. The result sits in an output register; if
// the receiver stalls and a new result is due, the block holds in its final
// step until the old one is taken, and no input is taken meanwhile.
// Reset (synchronous, active high) restores register defaults, clears the
// tracking state and drops out_valid.
module ray_triangle_nearest_hit_top
  import rtnh_pkg::*;
#(
  parameter int unsigned MAX_FACES = MaxFacesDefault
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [AddrW-1:0]         paddr,
  input  logic [DataW-1:0]         pwdata,
  output logic [DataW-1:0]         prdata,
  output logic                     pready,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [CoordW-1:0] a_x,
  input  logic signed [CoordW-1:0] a_y,
  input  logic signed [CoordW-1:0] a_z,
  input  logic signed [CoordW-1:0] b_x,
  input  logic signed [CoordW-1:0] b_y,
  input  logic signed [CoordW-1:0] b_z,
  input  logic signed [CoordW-1:0] c_x,
  input  logic signed [CoordW-1:0] c_y,
  input  logic signed [CoordW-1:0] c_z,
  input  logic                     last_triangle,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     hit,
  output logic [DistW-1:0]         hit_distance,
  output logic signed [VecW-1:0]   normal_x,
  output logic signed [VecW-1:0]   normal_y,
  output logic signed [VecW-1:0]   normal_z,
  output logic [FaceW-1:0]         hit_face
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MAC   = 7'b0000010,
    S_NORM  = 7'b0000100,
    S_CHECK = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_UPD   = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  localparam int unsigned CntW = 25;

  state_t state;

  // Configuration registers.
  logic signed [CoordW-1:0] origin [3];
  logic signed [CoordW-1:0] dir [3];
  logic                     cull;
  logic [DistW-1:0]         min_dist;

  // Tracking state.
  logic                   found;
  logic [DistW-1:0]       best_dist;
  logic signed [VecW-1:0] best_n [3];
  logic [FaceW-1:0]       best_face;
  logic [FaceW-1:0]       face_cnt;

  // Working registers of the current triangle.
  logic signed [EdgeW-1:0] e1 [3];
  logic signed [EdgeW-1:0] e2 [3];
  logic signed [EdgeW-1:0] sv [3];
  logic signed [VecW-1:0]  hv [3];
  logic signed [VecW-1:0]  qv [3];
  logic signed [VecW-1:0]  nv [3];
  logic signed [AccW-1:0]  det;
  logic signed [AccW-1:0]  un;
  logic signed [AccW-1:0]  vn;
  logic signed [AccW-1:0]  tn;
  logic signed [AccW-1:0]  nd;
  logic signed [AccW-1:0]  acc;
  logic                    is_last;
  logic                    reject;

  // Multiplier pipeline.
  logic [StepW-1:0]        step;
  mac_op_t                 op;
  mac_op_t                 p_op;
  logic                    p_v;
  logic signed [ProdW-1:0] prod;
  logic signed [EdgeW-1:0] mul_a;
  logic signed [VecW-1:0]  mul_b;
  logic signed [AccW-1:0]  acc_next;
  logic signed [AccW-1:0]  prod_ext;

  // Divider.
  logic [AccW-1:0]    rem;
  logic [AccW-1:0]    rem_shift;
  logic [DistW-1:0]   quo;
  logic [DistW-1:0]   nbits;
  logic [DivCntW-1:0] div_cnt;

  logic signed [AccW:0] uv_sum;
  logic [CntW-1:0]      face_inc;
  logic [FaceW-1:0]     face_next;
  logic                 cfg_wr;
  logic                 in_acc;
  logic                 fin_go;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign in_stall = (state != S_IDLE);
  assign in_acc = in_valid && (state == S_IDLE);
  assign fin_go = (state == S_FIN) && (!is_last || !out_valid || !out_stall);

  always_comb begin
    case (paddr[4:2])
      RegOriginX: prdata = 32'({16'b0, origin[0]});
      RegOriginY: prdata = 32'({16'b0, origin[1]});
      RegOriginZ: prdata = 32'({16'b0, origin[2]});
      RegDirX:    prdata = 32'({16'b0, dir[0]});
      RegDirY:    prdata = 32'({16'b0, dir[1]});
      RegDirZ:    prdata = 32'({16'b0, dir[2]});
      RegCull:    prdata = 32'({31'b0, cull});
      RegMinDist: prdata = min_dist;
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      origin[0] <= '0;
      origin[1] <= '0;
      origin[2] <= '0;
      dir[0] <= '0;
      dir[1] <= '0;
      dir[2] <= 16'sd256;
      cull <= 1'b0;
      min_dist <= 32'd1;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        RegOriginX: origin[0] <= pwdata[15:0];
        RegOriginY: origin[1] <= pwdata[15:0];
        RegOriginZ: origin[2] <= pwdata[15:0];
        RegDirX:    dir[0] <= pwdata[15:0];
        RegDirY:    dir[1] <= pwdata[15:0];
        RegDirZ:    dir[2] <= pwdata[15:0];
        RegCull:    cull <= pwdata[0];
        RegMinDist: min_dist <= pwdata;
        default:    cull <= cull;
      endcase
    end
  end

  // Operand selection for the shared multiplier.
  assign op = mac_op(step);

  always_comb begin
    case (op.a_src)
      A_E1:    mul_a = e1[op.a_idx];
      A_E2:    mul_a = e2[op.a_idx];
      A_S:     mul_a = sv[op.a_idx];
      default: mul_a = EdgeW'(dir[op.a_idx]);
    endcase
    case (op.b_src)
      B_DIR:   mul_b = VecW'(dir[op.b_idx]);
      B_S:     mul_b = VecW'(sv[op.b_idx]);
      B_E1:    mul_b = VecW'(e1[op.b_idx]);
      B_H:     mul_b = hv[op.b_idx];
      B_Q:     mul_b = qv[op.b_idx];
      B_N:     mul_b = nv[op.b_idx];
      default: mul_b = '0;
    endcase
  end

  assign prod_ext = AccW'(prod);
  assign acc_next = (p_op.first ? '0 : acc) + (p_op.neg ? -prod_ext : prod_ext);
  assign uv_sum = (AccW + 1)'(un) + (AccW + 1)'(vn);
  assign rem_shift = {rem[AccW-2:0], nbits[DistW-1]};
  assign face_inc = CntW'(face_cnt) + CntW'(1);
  assign face_next = (face_inc == CntW'(MAX_FACES)) ? '0 : face_inc[FaceW-1:0];

  always_ff @(posedge clk) begin
    prod <= ProdW'(mul_a * mul_b);
    p_op <= op;
    if (in_acc) begin
      e1[0] <= EdgeW'(b_x) - EdgeW'(a_x);
      e1[1] <= EdgeW'(b_y) - EdgeW'(a_y);
      e1[2] <= EdgeW'(b_z) - EdgeW'(a_z);
      e2[0] <= EdgeW'(c_x) - EdgeW'(a_x);
      e2[1] <= EdgeW'(c_y) - EdgeW'(a_y);
      e2[2] <= EdgeW'(c_z) - EdgeW'(a_z);
      sv[0] <= EdgeW'(origin[0]) - EdgeW'(a_x);
      sv[1] <= EdgeW'(origin[1]) - EdgeW'(a_y);
      sv[2] <= EdgeW'(origin[2]) - EdgeW'(a_z);
      is_last <= last_triangle;
    end
    if (p_v) begin
      acc <= acc_next;
      if (p_op.last) begin
        case (p_op.dest)
          D_H:     hv[p_op.dst_idx] <= acc_next[VecW-1:0];
          D_Q:     qv[p_op.dst_idx] <= acc_next[VecW-1:0];
          D_N:     nv[p_op.dst_idx] <= acc_next[VecW-1:0];
          D_DET:   det <= acc_next;
          D_UN:    un <= acc_next;
          D_VN:    vn <= acc_next;
          D_TN:    tn <= acc_next;
          default: nd <= acc_next;
        endcase
      end
    end
    if (state == S_NORM) begin
      // Fold the sign of the determinant into the numerators.
      if (det[AccW-1]) begin
        det <= -det;
        un <= -un;
        vn <= -vn;
        tn <= -tn;
      end
      reject <= (det == '0) ||
                (nv[0] == '0 && nv[1] == '0 && nv[2] == '0) ||
                (cull && !nd[AccW-1]);
    end
    if (state == S_CHECK) begin
      if (un < 0 || un > det || vn < 0 || uv_sum > (AccW + 1)'(det) || tn < 0) begin
        reject <= 1'b1;
      end
      rem <= AccW'(tn >>> 16);
      nbits <= {tn[15:0], 16'b0};
      // Integer part above 16 bits saturates the distance.
      if ((tn >>> 16) >= det) begin
        quo <= '1;
        div_cnt <= DivCntW'(DivSteps);
      end else begin
        quo <= '0;
        div_cnt <= '0;
      end
    end
    if (state == S_DIV) begin
      if (rem_shift >= AccW'(det)) begin
        rem <= rem_shift - AccW'(det);
        quo <= {quo[DistW-2:0], 1'b1};
      end else begin
        rem <= rem_shift;
        quo <= {quo[DistW-2:0], 1'b0};
      end
      nbits <= {nbits[DistW-2:0], 1'b0};
      div_cnt <= div_cnt + DivCntW'(1);
    end
    if (state == S_FIN && fin_go && is_last) begin
      hit <= found;
      hit_distance <= found ? best_dist : '0;
      normal_x <= found ? best_n[0] : '0;
      normal_y <= found ? best_n[1] : '0;
      normal_z <= found ? best_n[2] : '0;
      hit_face <= found ? best_face : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step <= '0;
      p_v <= 1'b0;
      out_valid <= 1'b0;
      found <= 1'b0;
      best_dist <= '1;
      best_n[0] <= '0;
      best_n[1] <= '0;
      best_n[2] <= '0;
      best_face <= '0;
      face_cnt <= '0;
    end else begin
      p_v <= (state == S_MAC) && (step != StepW'(NumSteps));
      // A new result loads as the old one leaves; a stalled one stays.
      out_valid <= (fin_go && is_last) || (out_valid && out_stall);
      case (state)
        S_IDLE: begin
          step <= '0;
          if (in_acc) begin
            state <= S_MAC;
          end
        end
        S_MAC: begin
          if (step == StepW'(NumSteps)) begin
            state <= S_NORM;
          end else begin
            step <= step + StepW'(1);
          end
        end
        S_NORM: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (un < 0 || un > det || vn < 0 || uv_sum > (AccW + 1)'(det) || tn < 0 ||
              reject) begin
            state <= S_FIN;
          end else if ((tn >>> 16) >= det) begin
            state <= S_UPD;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_cnt == DivCntW'(DivSteps - 1)) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          state <= S_FIN;
          if (quo >= min_dist && !(found && quo >= best_dist)) begin
            found <= 1'b1;
            best_dist <= quo;
            best_n[0] <= nv[0];
            best_n[1] <= nv[1];
            best_n[2] <= nv[2];
            best_face <= face_cnt;
          end
        end
        S_FIN: begin
          if (fin_go) begin
            state <= S_IDLE;
            if (is_last) begin
              found <= 1'b0;
              best_dist <= '1;
              best_n[0] <= '0;
              best_n[1] <= '0;
              best_n[2] <= '0;
              best_face <= '0;
              face_cnt <= '0;
            end else begin
              face_cnt <= face_next;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // A result appears only when a last triangle finishes.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FIN && is_last)
    else $error("result issued outside the final step of a mesh");

  // A taken result is not repeated unless a new one is loaded.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !fin_go |=> !out_valid)
    else $error("result repeated after it was taken");

  // A result without a hit carries no distance and no face.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> hit_distance == '0 && hit_face == '0)
    else $error("miss result carries hit data");

  // The multiplier sequence never runs past its table.
  assert property (@(posedge clk) disable iff (rst)
    state == S_MAC |-> step <= StepW'(NumSteps))
    else $error("multiply sequence overran");
`endif

endmodule
